>>> rtl/core/great_circle_distance_macros.svh
// ----------------------------------------------------------------------------
// great_circle_distance_macros
// Assertion macros for the great-circle distance top level.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH

// Check on every clock edge outside reset
`define GCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define GCD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, fixed-point constants and the CORDIC arctangent table for
// the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int XY_W         = 34;
  localparam int LAT_W        = 24;
  localparam int LON_W        = 25;
  localparam int DIFF_W       = 26;
  localparam int MAG_W        = 24;
  localparam int DIST_W       = 26;
  localparam int RAD_W        = 16;
  localparam int ROT_LANES    = 4;
  localparam int SQ_LANES     = 2;
  localparam int Q_W          = 31;
  localparam int ROOT_W       = 31;
  localparam int REM_W        = 61;
  localparam int SQRT_STEPS   = 31;
  localparam int FRONT_LAT    = 5;
  localparam int POST_LAT     = 2;
  localparam int PIPE_LAT     = FRONT_LAT + 2 * CORDIC_STEPS + POST_LAT + SQRT_STEPS;

  // Degrees to radians: product, rounding offset, shift and divide by 45
  localparam int SHIFT_FULL = 18;
  localparam int SHIFT_HALF = 19;
  localparam int SPLIT      = 19;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [56:0] RND_FULL  = 57'd5898240;
  localparam logic [56:0] RND_HALF  = 57'd11796480;
  localparam logic [26:0] RECIP45   = 27'd95443718;
  localparam logic [18:0] DIV45     = 19'd45;

  localparam logic signed [XY_W-1:0]   CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XY_W-1:0]   Q_ONE       = 34'sd1073741824;
  localparam logic [Q_W-1:0]           Q_ONE_U     = 31'd1073741824;
  localparam logic signed [LAT_W-1:0]  LAT_LIMIT   = 24'sd5898240;
  localparam logic signed [LON_W-1:0]  LON_LIMIT   = 25'sd11796480;
  localparam logic signed [DIFF_W-1:0] DEG180      = 26'sd11796480;
  localparam logic signed [DIFF_W-1:0] DEG360      = 26'sd23592960;
  localparam logic [47:0]              DIST_RND    = 48'd1048576;
  localparam logic [26:0]              DIST_MAX    = 27'd52706304;
  localparam logic [RAD_W-1:0]         RADIUS_RST  = 16'd6371;

  typedef logic signed [XY_W-1:0] gcd_xy_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] gcd_atan(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/gcd_ifs.sv
// ----------------------------------------------------------------------------
// gcd channel interfaces
// Valid/ready channels for point pairs in and distances out.
// ----------------------------------------------------------------------------
interface gcd_in_if;
  logic                valid;
  logic                ready;
  logic signed [23:0]  first_latitude;
  logic signed [24:0]  first_longitude;
  logic signed [23:0]  second_latitude;
  logic signed [24:0]  second_longitude;

  modport source (output valid, first_latitude, first_longitude,
                  second_latitude, second_longitude, input ready);
  modport sink   (input valid, first_latitude, first_longitude,
                  second_latitude, second_longitude, output ready);
endinterface

interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] arc_distance;

  modport source (output valid, arc_distance, input ready);
  modport sink   (input valid, arc_distance, output ready);
endinterface

>>> rtl/core/gcd_front.sv
// ----------------------------------------------------------------------------
// gcd_front
// Clamps the coordinates, forms the differences and converts the four CORDIC
// angles to Q2.30 radians with rounding, over five register stages.
// ----------------------------------------------------------------------------
module gcd_front
  import gcd_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [LAT_W-1:0] first_latitude,
  input  logic signed [LON_W-1:0] first_longitude,
  input  logic signed [LAT_W-1:0] second_latitude,
  input  logic signed [LON_W-1:0] second_longitude,
  output gcd_xy_t                 ang_o [ROT_LANES]
);

  logic signed [LAT_W-1:0]  lat1c, lat2c;
  logic signed [LON_W-1:0]  lon1c, lon2c;
  logic signed [DIFF_W-1:0] dlat, dlon, dlonf;
  logic signed [DIFF_W-1:0] val [ROT_LANES];

  logic [MAG_W-1:0] m1_nxt [ROT_LANES], m1_r [ROT_LANES];
  logic [55:0]      p2_nxt [ROT_LANES], p2_r [ROT_LANES];
  logic [45:0]      th3_nxt [ROT_LANES], th3_r [ROT_LANES];
  logic [18:0]      xh3_nxt [ROT_LANES], xh3_r [ROT_LANES];
  logic [18:0]      xl3_nxt [ROT_LANES], xl3_r [ROT_LANES];
  logic [51:0]      tl4_nxt [ROT_LANES], tl4_r [ROT_LANES];
  logic [13:0]      qh4_nxt [ROT_LANES], qh4_r [ROT_LANES];
  gcd_xy_t          ang_nxt [ROT_LANES], ang_r [ROT_LANES];
  logic [ROT_LANES-1:0] neg1_r, neg2_r, neg3_r, neg4_r, neg1_nxt;

  // Clamp, difference and fold the longitude gap into a half turn
  always_comb begin
    lat1c = (first_latitude > LAT_LIMIT) ? LAT_LIMIT :
            (first_latitude < -LAT_LIMIT) ? -LAT_LIMIT : first_latitude;
    lat2c = (second_latitude > LAT_LIMIT) ? LAT_LIMIT :
            (second_latitude < -LAT_LIMIT) ? -LAT_LIMIT : second_latitude;
    lon1c = (first_longitude > LON_LIMIT) ? LON_LIMIT :
            (first_longitude < -LON_LIMIT) ? -LON_LIMIT : first_longitude;
    lon2c = (second_longitude > LON_LIMIT) ? LON_LIMIT :
            (second_longitude < -LON_LIMIT) ? -LON_LIMIT : second_longitude;
    dlat  = DIFF_W'(lat2c) - DIFF_W'(lat1c);
    dlon  = DIFF_W'(lon2c) - DIFF_W'(lon1c);
    if (dlon > DEG180) begin
      dlonf = DEG360 - dlon;
    end else if (dlon < -DEG180) begin
      dlonf = -DEG360 - dlon;
    end else begin
      dlonf = dlon;
    end
    val[0] = DIFF_W'(lat1c);
    val[1] = DIFF_W'(lat2c);
    val[2] = dlat;
    val[3] = dlonf;
    for (int l = 0; l < ROT_LANES; l++) begin
      neg1_nxt[l] = val[l][DIFF_W-1];
      m1_nxt[l]   = neg1_nxt[l] ? MAG_W'(-val[l]) : MAG_W'(val[l]);
    end
  end

  // Multiply by pi, then divide by 45 in two reciprocal digits
  always_comb begin
    logic [56:0] n;
    logic [37:0] x;
    logic [18:0] rh;
    logic [24:0] lo;
    logic [19:0] ql;
    logic [32:0] r;
    for (int l = 0; l < ROT_LANES; l++) begin
      p2_nxt[l]  = 56'(m1_r[l]) * 56'(PI_Q30);
      n          = 57'(p2_r[l]) + ((l < 2) ? RND_FULL : RND_HALF);
      x          = (l < 2) ? 38'(n >> SHIFT_FULL) : 38'(n >> SHIFT_HALF);
      xh3_nxt[l] = x[37:SPLIT];
      xl3_nxt[l] = x[SPLIT-1:0];
      th3_nxt[l] = 46'(xh3_nxt[l]) * 46'(RECIP45);
      qh4_nxt[l] = th3_r[l][45:32];
      rh         = xh3_r[l] - 19'(qh4_nxt[l]) * DIV45;
      lo         = {rh[5:0], xl3_r[l]};
      tl4_nxt[l] = 52'(lo) * 52'(RECIP45);
      ql         = tl4_r[l][51:32];
      r          = {qh4_r[l], 19'b0} + 33'(ql);
      ang_nxt[l] = neg4_r[l] ? -gcd_xy_t'(XY_W'(r)) : gcd_xy_t'(XY_W'(r));
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= neg1_nxt;
      neg2_r <= neg1_r;
      neg3_r <= neg2_r;
      neg4_r <= neg3_r;
      m1_r   <= m1_nxt;
      p2_r   <= p2_nxt;
      th3_r  <= th3_nxt;
      xh3_r  <= xh3_nxt;
      xl3_r  <= xl3_nxt;
      tl4_r  <= tl4_nxt;
      qh4_r  <= qh4_nxt;
      ang_r  <= ang_nxt;
    end
  end

  assign ang_o = ang_r;

endmodule

>>> rtl/core/gcd_rot_cell.sv
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One registered rotation-mode CORDIC iteration.
// ----------------------------------------------------------------------------
module gcd_rot_cell
  import gcd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  gcd_xy_t           x_i,
  input  gcd_xy_t           y_i,
  input  gcd_xy_t           z_i,
  output gcd_xy_t           x_o,
  output gcd_xy_t           y_o,
  output gcd_xy_t           z_o
);

  gcd_xy_t dx, dy, at;
  gcd_xy_t x_nxt, y_nxt, z_nxt, x_r, y_r, z_r;

  // Rotate towards zero residual angle
  always_comb begin
    dx = y_i >>> step;
    dy = x_i >>> step;
    at = gcd_xy_t'({{(XY_W-32){1'b0}}, gcd_atan(step)});
    if (!z_i[XY_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - at;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> rtl/core/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One registered digit of a restoring integer square root.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell
  import gcd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [REM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt, rem_r;
  logic [ROOT_W-1:0] root_nxt, root_r;

  // Try setting this root bit against the remainder
  always_comb begin
    trial    = ((REM_W + 2)'(root_i) << (6'(step) + 6'd1))
             | ((REM_W + 2)'(1) << {step, 1'b0});
    ge       = {2'b00, rem_i} >= trial;
    rem_nxt  = ge ? (rem_i - trial[REM_W-1:0]) : rem_i;
    root_nxt = ge ? (root_i | (ROOT_W'(1) << step)) : root_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

>>> rtl/core/gcd_vec_cell.sv
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One registered vectoring-mode CORDIC iteration for atan2.
// ----------------------------------------------------------------------------
module gcd_vec_cell
  import gcd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  gcd_xy_t           x_i,
  input  gcd_xy_t           y_i,
  input  gcd_xy_t           z_i,
  output gcd_xy_t           x_o,
  output gcd_xy_t           y_o,
  output gcd_xy_t           z_o
);

  gcd_xy_t dx, dy, at;
  gcd_xy_t x_nxt, y_nxt, z_nxt, x_r, y_r, z_r;

  // Drive y towards zero and accumulate the angle
  always_comb begin
    dx = y_i >>> step;
    dy = x_i >>> step;
    at = gcd_xy_t'({{(XY_W-32){1'b0}}, gcd_atan(step)});
    if (!y_i[XY_W-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + at;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> rtl/core/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine distance between two points: CORDIC rotation cells, square-root
// digit cells, CORDIC vectoring cells; one transaction a cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_chan   sink       first/second latitude and longitude, deg * 65536
//  out_chan  source     arc_distance, km * 256
//  cfg_*     write      sphere_radius_km, 16 bits
//
//  One transaction enters per cycle unless the chain stalls; each accepted
//  transaction passes through 5 conversion stages, 20 rotation cells, 2
//  product stages, 31 root cells, 20 vectoring cells and the output register.
//  Reset clears the valid chain and sets the radius to 6371 km; no input is
//  taken while reset is asserted.
//  When the output register holds an untaken result the whole chain stalls.
// ----------------------------------------------------------------------------
`include "great_circle_distance_macros.svh"

module great_circle_distance
  import gcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  gcd_in_if.sink           in_chan,
  gcd_out_if.source        out_chan,
  input  logic             cfg_wr_en,
  input  logic [RAD_W-1:0] cfg_wr_data
);

  logic                en;
  logic [PIPE_LAT-1:0] vld_r, vld_nxt;
  logic                out_valid_r;
  logic [DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic [RAD_W-1:0]    radius_r;

  gcd_xy_t front_ang [ROT_LANES];
  gcd_xy_t rot_x [CORDIC_STEPS+1][ROT_LANES];
  gcd_xy_t rot_y [CORDIC_STEPS+1][ROT_LANES];
  gcd_xy_t rot_z [CORDIC_STEPS+1][ROT_LANES];

  logic [REM_W-1:0]  sq_rem  [SQRT_STEPS+1][SQ_LANES];
  logic [ROOT_W-1:0] sq_root [SQRT_STEPS+1][SQ_LANES];

  gcd_xy_t vec_x [CORDIC_STEPS+1];
  gcd_xy_t vec_y [CORDIC_STEPS+1];
  gcd_xy_t vec_z [CORDIC_STEPS+1];

  logic [Q_W-1:0] sl2_nxt, so2_nxt, cc_nxt, sl2_r, so2_r, cc_r;
  logic [Q_W-1:0] a_nxt, a_r;

  // Advance unless a finished result is waiting; hold the input off in reset
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en && rst_n;
  assign vld_nxt       = {vld_r[PIPE_LAT-2:0], in_chan.valid};

  gcd_front u_front (
    .clk              (clk),
    .en               (en),
    .first_latitude   (in_chan.first_latitude),
    .first_longitude  (in_chan.first_longitude),
    .second_latitude  (in_chan.second_latitude),
    .second_longitude (in_chan.second_longitude),
    .ang_o            (front_ang)
  );

  // Rotation chain: lanes lat1, lat2, half dlat, half dlon
  for (genvar l = 0; l < ROT_LANES; l++) begin : g_rot_init
    assign rot_x[0][l] = CORDIC_GAIN;
    assign rot_y[0][l] = '0;
    assign rot_z[0][l] = front_ang[l];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    for (genvar l = 0; l < ROT_LANES; l++) begin : g_lane
      gcd_rot_cell u_cell (
        .clk  (clk),
        .en   (en),
        .step (STEP_W'(i)),
        .x_i  (rot_x[i][l]),
        .y_i  (rot_y[i][l]),
        .z_i  (rot_z[i][l]),
        .x_o  (rot_x[i+1][l]),
        .y_o  (rot_y[i+1][l]),
        .z_o  (rot_z[i+1][l])
      );
    end
  end

  // Clamp the CORDIC outputs and form the squares and cosine product
  always_comb begin
    logic [Q_W-1:0]       c1, c2;
    logic signed [31:0]   sl, so;
    logic signed [63:0]   sqa, sqb;
    logic [61:0]          pc;
    c1 = (rot_x[CORDIC_STEPS][0] < 0) ? '0 :
         (rot_x[CORDIC_STEPS][0] > Q_ONE) ? Q_ONE_U : Q_W'(rot_x[CORDIC_STEPS][0]);
    c2 = (rot_x[CORDIC_STEPS][1] < 0) ? '0 :
         (rot_x[CORDIC_STEPS][1] > Q_ONE) ? Q_ONE_U : Q_W'(rot_x[CORDIC_STEPS][1]);
    sl = (rot_y[CORDIC_STEPS][2] > Q_ONE) ? 32'(Q_ONE) :
         (rot_y[CORDIC_STEPS][2] < -Q_ONE) ? 32'(-Q_ONE) : 32'(rot_y[CORDIC_STEPS][2]);
    so = (rot_y[CORDIC_STEPS][3] > Q_ONE) ? 32'(Q_ONE) :
         (rot_y[CORDIC_STEPS][3] < -Q_ONE) ? 32'(-Q_ONE) : 32'(rot_y[CORDIC_STEPS][3]);
    sqa     = 64'(sl) * 64'(sl);
    sqb     = 64'(so) * 64'(so);
    pc      = 62'(c1) * 62'(c2);
    sl2_nxt = sqa[60:30];
    so2_nxt = sqb[60:30];
    cc_nxt  = pc[60:30];
  end

  // Sum the haversine term and clamp to one
  always_comb begin
    logic [61:0] pt;
    logic [31:0] asum;
    pt    = 62'(cc_r) * 62'(so2_r);
    asum  = 32'(sl2_r) + 32'(pt[60:30]);
    a_nxt = (asum > 32'(Q_ONE_U)) ? Q_ONE_U : asum[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl2_r <= sl2_nxt;
      so2_r <= so2_nxt;
      cc_r  <= cc_nxt;
      a_r   <= a_nxt;
    end
  end

  // Root chain: sqrt(a) and sqrt(1 - a), one bit per cell
  assign sq_rem[0][0]  = {a_r, 30'b0};
  assign sq_rem[0][1]  = {Q_ONE_U - a_r, 30'b0};
  assign sq_root[0][0] = '0;
  assign sq_root[0][1] = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    for (genvar l = 0; l < SQ_LANES; l++) begin : g_lane
      gcd_sqrt_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step   (STEP_W'(SQRT_STEPS - 1 - j)),
        .rem_i  (sq_rem[j][l]),
        .root_i (sq_root[j][l]),
        .rem_o  (sq_rem[j+1][l]),
        .root_o (sq_root[j+1][l])
      );
    end
  end

  // Vectoring chain: atan2(sqrt(a), sqrt(1 - a))
  assign vec_y[0] = gcd_xy_t'(XY_W'(sq_root[SQRT_STEPS][0]));
  assign vec_x[0] = gcd_xy_t'(XY_W'(sq_root[SQRT_STEPS][1]));
  assign vec_z[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    gcd_vec_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(i)),
      .x_i  (vec_x[i]),
      .y_i  (vec_y[i]),
      .z_i  (vec_z[i]),
      .x_o  (vec_x[i+1]),
      .y_o  (vec_y[i+1]),
      .z_o  (vec_z[i+1])
    );
  end

  // Scale by the radius, round and cap
  always_comb begin
    logic [31:0] angu;
    logic [47:0] prod;
    logic [26:0] d;
    angu         = vec_z[CORDIC_STEPS][XY_W-1] ? '0 : vec_z[CORDIC_STEPS][31:0];
    prod         = 48'(radius_r) * 48'(angu) + DIST_RND;
    d            = prod[47:21];
    out_dist_nxt = (d > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : d[DIST_W-1:0];
  end

  // Hold valid chain, output register and radius
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      radius_r    <= RADIUS_RST;
    end else begin
      if (en) begin
        vld_r       <= vld_nxt;
        out_valid_r <= vld_r[PIPE_LAT-1];
      end
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r <= out_dist_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.arc_distance = out_dist_r;

  `GCD_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_chan.valid, "output valid after reset")
  `GCD_ASSERT(a_tail_reaches_out, vld_r[PIPE_LAT-1] && en |=> out_valid_r, "transaction lost at output")
  `GCD_ASSERT(a_stall_freezes, !en |=> $stable(vld_r), "valid chain moved during stall")
  `GCD_ASSERT(a_dist_capped, out_valid_r |-> ({1'b0, out_dist_r} <= DIST_MAX), "distance above cap")

endmodule
